FILE: rtl/core/bfta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfta_pkg: shared definitions of the best-fit table allocator
// Field widths, slot limits, outcome and register codes, and the status
// record that the fit search hands to the top level.
// ----------------------------------------------------------------------------
package bfta_pkg;

	// Default sizes of the table and of the requester map.
	localparam int NUM_SLOTS_DEF = 12;
	localparam int MAX_REQ_DEF   = 64;

	// Fixed field widths.
	localparam int CAP_W     = 5;
	localparam int TABLE_W   = 60;
	localparam int COUNT_W   = 4;
	localparam int ID_W      = 6;
	localparam int SIZE_W    = 5;
	localparam int SLOT_W    = 4;
	localparam int SUM_W     = 16;
	localparam int CFG_IDX_W = 1;

	// Capacities at or above this limit are never chosen.
	localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(21);

	// Event kinds.
	localparam logic ACT_ARRIVE = 1'b0;
	localparam logic ACT_DEPART = 1'b1;

	// Result codes.
	typedef enum logic [1:0] {
		OUT_SEATED  = 2'd0,
		OUT_REFUSED = 2'd1,
		OUT_FREED   = 2'd2,
		OUT_IGNORED = 2'd3
	} outcome_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TABLE_SIZES = 1'b0,
		REG_TABLE_COUNT = 1'b1
	} cfg_reg_t;

	// Status of one best-fit search.
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
	} fit_result_t;

endpackage

FILE: rtl/core/bfta_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfta_if: event and result channels of the best-fit table allocator
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ----------------------------------------------------------------------------

// Event channel: an arrival or a departure of one requester.
interface bfta_evt_if
	import bfta_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              action;
	logic [ID_W-1:0]   group_id;
	logic [SIZE_W-1:0] group_size;

	modport source(output valid, output action, output group_id, output group_size,
		input ready);
	modport sink(input valid, input action, input group_id, input group_size,
		output ready);
endinterface

// Result channel: one result per event.
interface bfta_res_if
	import bfta_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [1:0]        outcome;
	logic [SLOT_W-1:0] slot_index;
	logic [SUM_W-1:0]  refused_total;

	modport source(output valid, output outcome, output slot_index, output refused_total,
		input ready);
	modport sink(input valid, input outcome, input slot_index, input refused_total,
		output ready);
endinterface

FILE: rtl/core/bfta_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfta_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data. A read and a
// write to the same address in one cycle return the old contents.
// ----------------------------------------------------------------------------
module bfta_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/bfta_fit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfta_fit: best-fit slot search
// Compares every slot against the request in parallel and picks the free
// slot with the smallest capacity that still fits, lowest index on a tie.
// ----------------------------------------------------------------------------
module bfta_fit
	import bfta_pkg::*;
#(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic [TABLE_W-1:0]   table_sizes,
	input  logic [COUNT_W-1:0]   table_count,
	input  logic [NUM_SLOTS-1:0] busy,
	input  logic [SIZE_W-1:0]    size,
	output fit_result_t          fit
);

	logic [COUNT_W-1:0]   slots_used;
	logic [CAP_W-1:0]     cap [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] elig;
	logic [NUM_SLOTS-1:0] win;

	// A count above the table size acts as the table size.
	assign slots_used = (table_count > COUNT_W'(NUM_SLOTS)) ? COUNT_W'(NUM_SLOTS)
		: table_count;

	// A slot is a candidate when it is in use, free, large enough and below the limit.
	always_comb begin
		for (int t = 0; t < NUM_SLOTS; t++) begin
			cap[t]  = table_sizes[t*CAP_W +: CAP_W];
			elig[t] = (COUNT_W'(t) < slots_used) && !busy[t]
				&& ({1'b0, cap[t]} >= {1'b0, size}) && (cap[t] < CAP_LIMIT);
		end
	end

	// A candidate wins when no other candidate is smaller, or equal at a lower index.
	always_comb begin
		for (int t = 0; t < NUM_SLOTS; t++) begin
			win[t] = elig[t];
			for (int u = 0; u < NUM_SLOTS; u++) begin
				if (u != t && elig[u]
					&& ((cap[u] < cap[t]) || ((cap[u] == cap[t]) && (u < t)))) begin
					win[t] = 1'b0;
				end
			end
		end
	end

	// Encode the single winner.
	always_comb begin
		fit.found = |elig;
		fit.slot  = '0;
		for (int t = 0; t < NUM_SLOTS; t++) begin
			if (win[t]) begin
				fit.slot = fit.slot | SLOT_W'(t);
			end
		end
	end

endmodule

FILE: rtl/core/best_fit_table_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_table_allocator_top: best-fit slot allocator over a sized table
// Seats arriving requesters in the smallest free slot that fits and frees
// the slot on departure; keeps a saturating total of refused sizes.
// ----------------------------------------------------------------------------
// The block takes one event per clock cycle while the result channel does
// not stall and returns exactly one result per event, in order. An event is
// evaluated from the input register and its result is offered from the
// result register; while the result channel stalls, one more event waits in
// the input register and then the event channel drops ready. The rate is set
// by the single read port of the requester map RAM, which is read at the
// transfer of each event, and by the combinational fit search over all slots.
// The requester map needs no clearing pass: its valid bits are flops cleared
// by reset. The user must write table sizes and count through the plain
// configuration port while no event is in flight; the block does not check.
// ----------------------------------------------------------------------------
module best_fit_table_allocator_top
	import bfta_pkg::*;
#(
	parameter int NUM_SLOTS      = NUM_SLOTS_DEF,
	parameter int MAX_REQUESTERS = MAX_REQ_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TABLE_W-1:0]   cfg_data,
	bfta_evt_if.sink             evt,
	bfta_res_if.source           res
);

	localparam int IDX_W = (MAX_REQUESTERS > 1) ? $clog2(MAX_REQUESTERS) : 1;
	localparam int ID_RANGE = 1 << ID_W;

	// Configuration registers.
	logic [TABLE_W-1:0] table_sizes_q;
	logic [COUNT_W-1:0] table_count_q;

	// Handshake control.
	logic accept;
	logic advance;

	// Input register.
	logic              s1_valid_q;
	logic              action_s1;
	logic [IDX_W-1:0]  id_s1;
	logic [SIZE_W-1:0] size_s1;

	// Allocation state.
	logic [NUM_SLOTS-1:0]      busy_q;
	logic [MAX_REQUESTERS-1:0] held_q;
	logic [SUM_W-1:0]          refused_q;

	// Requester map and its forwarding path.
	logic [IDX_W-1:0]  id_in;
	logic [IDX_W-1:0]  id_tab [ID_RANGE];
	logic [SLOT_W-1:0] ram_rdata;
	logic              ram_we;
	logic              fwd_hit_q;
	logic [SLOT_W-1:0] fwd_slot_q;

	// Evaluation of the event in the input register.
	fit_result_t          fit;
	logic                 held;
	logic [SLOT_W-1:0]    held_slot;
	logic [NUM_SLOTS-1:0] busy_nxt;
	logic [SUM_W:0]       sum_wide;
	logic [SUM_W-1:0]     sum_nxt;
	outcome_t             outcome_nxt;
	logic [SLOT_W-1:0]    slot_nxt;
	logic                 held_set;
	logic                 held_clr;

	// Result register.
	logic              res_valid_q;
	outcome_t          outcome_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SUM_W-1:0]  total_q;

	// Configuration writes; an unknown index is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_sizes_q <= '0;
			table_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TABLE_SIZES: table_sizes_q <= cfg_data;
				REG_TABLE_COUNT: table_count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Constant table that folds the identifier into the map range.
	for (genvar g = 0; g < ID_RANGE; g++) begin : g_id_fold
		localparam int FOLD = g % MAX_REQUESTERS;
		assign id_tab[g] = IDX_W'(FOLD);
	end
	assign id_in = id_tab[evt.group_id];

	// The input register moves on when the result register is free or drains.
	assign advance   = s1_valid_q && (!res_valid_q || res.ready);
	assign evt.ready = !s1_valid_q || advance;
	assign accept    = evt.valid && evt.ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= evt.action;
			id_s1     <= id_in;
			size_s1   <= evt.group_size;
		end
	end

	// Requester map: slot per requester, read at transfer, written on seating.
	assign ram_we = advance && (action_s1 == ACT_ARRIVE) && fit.found;

	bfta_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (MAX_REQUESTERS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (id_s1),
		.wdata (fit.slot),
		.re    (accept),
		.raddr (id_in),
		.rdata (ram_rdata)
	);

	// Forward a map write that lands at the same edge as the read of the next event.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else if (accept) begin
			fwd_hit_q <= ram_we && (id_s1 == id_in);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_slot_q <= fit.slot;
		end
	end

	assign held      = held_q[id_s1];
	assign held_slot = fwd_hit_q ? fwd_slot_q : ram_rdata;

	// Best-fit search against the current occupancy.
	bfta_fit #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_fit (
		.table_sizes (table_sizes_q),
		.table_count (table_count_q),
		.busy        (busy_q),
		.size        (size_s1),
		.fit         (fit)
	);

	// Saturating refused total.
	assign sum_wide = {1'b0, refused_q} + (SUM_W + 1)'(size_s1);
	assign sum_nxt  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

	// Outcome and next occupancy of the event in the input register.
	always_comb begin
		busy_nxt    = busy_q;
		outcome_nxt = OUT_IGNORED;
		slot_nxt    = '0;
		held_set    = 1'b0;
		held_clr    = 1'b0;
		if (action_s1 == ACT_DEPART) begin
			if (held) begin
				for (int t = 0; t < NUM_SLOTS; t++) begin
					if (held_slot == SLOT_W'(t)) begin
						busy_nxt[t] = 1'b0;
					end
				end
				outcome_nxt = OUT_FREED;
				slot_nxt    = held_slot;
				held_clr    = 1'b1;
			end
		end else if (fit.found) begin
			// A seated requester gives up the slot it held before.
			for (int t = 0; t < NUM_SLOTS; t++) begin
				if (held && (held_slot == SLOT_W'(t))) begin
					busy_nxt[t] = 1'b0;
				end
				if (fit.slot == SLOT_W'(t)) begin
					busy_nxt[t] = 1'b1;
				end
			end
			outcome_nxt = OUT_SEATED;
			slot_nxt    = fit.slot;
			held_set    = 1'b1;
		end else begin
			outcome_nxt = OUT_REFUSED;
		end
	end

	// Commit the allocation state when the event moves to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= '0;
			held_q    <= '0;
			refused_q <= '0;
		end else if (advance) begin
			busy_q <= busy_nxt;
			if (held_set) begin
				held_q[id_s1] <= 1'b1;
			end else if (held_clr) begin
				held_q[id_s1] <= 1'b0;
			end
			if (outcome_nxt == OUT_REFUSED) begin
				refused_q <= sum_nxt;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			outcome_q <= outcome_nxt;
			slot_q    <= slot_nxt;
			total_q   <= (outcome_nxt == OUT_REFUSED) ? sum_nxt : refused_q;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.outcome       = outcome_q;
	assign res.slot_index    = slot_q;
	assign res.refused_total = total_q;

endmodule
